// ===== rtl/swks_pkg.sv =====
// shared constants and cell operation codes for the sliding-window k-smallest-sum block
`default_nettype none

package swks_pkg;

    localparam int SUM_BITS       = 38;
    localparam int REG_BITS       = 7;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_LEN = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_K_COUNT    = 1'b1;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_AGE,
        OP_REMOVE,
        OP_INSERT,
        OP_ROTATE
    } cell_op_t;

endpackage

`default_nettype wire

// ===== rtl/swks_cell.sv =====
// one window cell: holds a sample and its age, trades contents with its neighbors
`default_nettype none

module swks_cell
    import swks_pkg::*;
#(
    parameter int SAMPLE_BITS = 32,
    parameter int AGE_BITS    = 7
)(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  cell_op_t                    op,
    input  wire logic                   shift_up,
    input  wire logic [SAMPLE_BITS-1:0] x,
    input  wire logic                   left_valid,
    input  wire logic [SAMPLE_BITS-1:0] left_value,
    input  wire logic [AGE_BITS-1:0]    left_age,
    input  wire logic                   left_le,
    input  wire logic                   right_valid,
    input  wire logic [SAMPLE_BITS-1:0] right_value,
    input  wire logic [AGE_BITS-1:0]    right_age,
    input  wire logic [SAMPLE_BITS-1:0] wrap_value,
    input  wire logic [AGE_BITS-1:0]    wrap_age,
    output logic                        valid,
    output logic [SAMPLE_BITS-1:0]      value,
    output logic [AGE_BITS-1:0]         age,
    output logic                        le
);

    logic                   valid_reg;
    logic                   valid_next;
    logic [SAMPLE_BITS-1:0] value_reg;
    logic [SAMPLE_BITS-1:0] value_next;
    logic [AGE_BITS-1:0]    age_reg;
    logic [AGE_BITS-1:0]    age_next;

    assign le = valid_reg && (value_reg <= x);

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        age_next   = age_reg;
        unique case (op)
            OP_AGE:
            begin
                if (valid_reg)
                begin
                    age_next = age_reg + AGE_BITS'(1);
                end
            end
            OP_REMOVE:
            begin
                // close the gap left by the expired entry at or below this cell
                if (shift_up)
                begin
                    valid_next = right_valid;
                    value_next = right_value;
                    age_next   = right_age;
                end
            end
            OP_INSERT:
            begin
                if (!le)
                begin
                    if (left_le)
                    begin
                        valid_next = 1'b1;
                        value_next = x;
                        age_next   = '0;
                    end
                    else
                    begin
                        valid_next = left_valid;
                        value_next = left_value;
                        age_next   = left_age;
                    end
                end
            end
            OP_ROTATE:
            begin
                // last occupied cell picks up the head entry
                if (valid_reg)
                begin
                    if (right_valid)
                    begin
                        value_next = right_value;
                        age_next   = right_age;
                    end
                    else
                    begin
                        value_next = wrap_value;
                        age_next   = wrap_age;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        age_reg   <= age_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;
    assign age   = age_reg;

endmodule

`default_nettype wire

// ===== rtl/sliding_window_k_smallest_sum.sv =====
// top level: sorted chain of window cells with incremental k-smallest sum
//
// channel   dir  handshake             payload
// cfg       in   cfg_we                cfg_index, cfg_data
// in        in   in_valid / in_ready   sample
// out       out  out_valid / out_ready small_sum
//
// a transaction on in steps through accept (entries age), drop, sorted insert
// each extra entry expired by a shorter window repeats the drop step
// after a k_count write the next transaction first rotates the chain once,
// through every kept sample, to rebuild the sum
// reset empties the window; no clearing pass
// insert waits while a previous result is still held on out
`default_nettype none

module sliding_window_k_smallest_sum
    import swks_pkg::*;
#(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 32
)(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [REG_BITS-1:0]       cfg_data,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [SAMPLE_BITS-1:0]    sample,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [SUM_BITS-1:0]            small_sum
);

    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int KW = (CW > REG_BITS) ? CW : REG_BITS;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_SUMPASS = 2'd1;
    localparam logic [1:0] ST_REMOVE  = 2'd2;
    localparam logic [1:0] ST_INSERT  = 2'd3;

    logic [1:0]             state_reg;
    logic [1:0]             state_next;
    logic [REG_BITS-1:0]    window_len_reg;
    logic [REG_BITS-1:0]    window_len_next;
    logic [REG_BITS-1:0]    k_count_reg;
    logic [REG_BITS-1:0]    k_count_next;
    logic                   dirty_reg;
    logic                   dirty_next;
    logic [CW-1:0]          fill_reg;
    logic [CW-1:0]          fill_next;
    logic [CW-1:0]          cnt_reg;
    logic [CW-1:0]          cnt_next;
    logic [SUM_BITS-1:0]    sum_reg;
    logic [SUM_BITS-1:0]    sum_next;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [SAMPLE_BITS-1:0] sample_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [SUM_BITS-1:0]    out_sum_reg;
    logic [SUM_BITS-1:0]    out_sum_next;

    logic                   c_valid [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] c_value [MAX_WINDOW];
    logic [CW-1:0]          c_age   [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]  c_le;
    logic [MAX_WINDOW-1:0]  flag;
    logic [MAX_WINDOW-1:0]  below;
    logic [MAX_WINDOW-1:0]  first;
    logic [MAX_WINDOW-1:0]  rle;
    logic [MAX_WINDOW-1:0]  lt_kk;
    logic [MAX_WINDOW-1:0]  at_k;
    logic [MAX_WINDOW-1:0]  at_km1;

    cell_op_t               cell_op;
    logic [KW-1:0]          wl_ext;
    logic [KW-1:0]          wl_eff;
    logic [KW-1:0]          k_ext;
    logic [KW-1:0]          fill_ext;
    logic [KW-1:0]          kk;
    logic [SAMPLE_BITS-1:0] v_rem;
    logic [SAMPLE_BITS-1:0] v_hi;
    logic [SAMPLE_BITS-1:0] v_km1;
    logic                   accept;
    logic                   stall;
    logic                   any_flag;
    logic                   multi;
    logic                   r_in;
    logic                   le_km1;
    logic                   emit;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign stall     = out_valid_reg && !out_ready;
    assign out_valid = out_valid_reg;
    assign small_sum = out_sum_reg;

    always_comb
    begin
        wl_ext = KW'(window_len_reg);
        if (wl_ext == '0)
        begin
            wl_eff = KW'(1);
        end
        else if (wl_ext > KW'(MAX_WINDOW))
        begin
            wl_eff = KW'(MAX_WINDOW);
        end
        else
        begin
            wl_eff = wl_ext;
        end
    end

    assign k_ext    = KW'(k_count_reg);
    assign fill_ext = KW'(fill_reg);
    assign kk       = (k_ext < fill_ext) ? k_ext : fill_ext;

    always_comb
    begin
        priority if (state_reg == ST_IDLE && accept)
        begin
            cell_op = OP_AGE;
        end
        else if (state_reg == ST_SUMPASS)
        begin
            cell_op = OP_ROTATE;
        end
        else if (state_reg == ST_REMOVE)
        begin
            cell_op = OP_REMOVE;
        end
        else if (state_reg == ST_INSERT && !stall)
        begin
            cell_op = OP_INSERT;
        end
        else
        begin
            cell_op = OP_HOLD;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_WINDOW; gi++)
        begin : g_cell
            localparam logic [MAX_WINDOW-1:0] LowMask =
                {MAX_WINDOW{1'b1}} >> (MAX_WINDOW - gi);
            localparam logic [KW-1:0] Idx     = KW'(gi);
            localparam logic [KW-1:0] IdxNext = KW'(gi + 1);

            logic                   l_valid;
            logic [SAMPLE_BITS-1:0] l_value;
            logic [CW-1:0]          l_age;
            logic                   l_le;
            logic                   r_valid;
            logic [SAMPLE_BITS-1:0] r_value;
            logic [CW-1:0]          r_age;

            if (gi == 0)
            begin : g_head
                assign l_valid = 1'b0;
                assign l_value = '0;
                assign l_age   = '0;
                assign l_le    = 1'b1;
            end
            else
            begin : g_body
                assign l_valid = c_valid[gi-1];
                assign l_value = c_value[gi-1];
                assign l_age   = c_age[gi-1];
                assign l_le    = c_le[gi-1];
            end

            if (gi == MAX_WINDOW - 1)
            begin : g_tail
                assign r_valid = 1'b0;
                assign r_value = '0;
                assign r_age   = '0;
            end
            else
            begin : g_inner
                assign r_valid = c_valid[gi+1];
                assign r_value = c_value[gi+1];
                assign r_age   = c_age[gi+1];
            end

            assign flag[gi]   = c_valid[gi] && (KW'(c_age[gi]) >= wl_eff);
            assign below[gi]  = |(flag & LowMask);
            assign first[gi]  = flag[gi] && !below[gi];
            assign rle[gi]    = flag[gi] || below[gi];
            assign lt_kk[gi]  = (Idx < kk);
            assign at_k[gi]   = (Idx == k_ext);
            assign at_km1[gi] = (IdxNext == k_ext);

            swks_cell #(
                .SAMPLE_BITS (SAMPLE_BITS),
                .AGE_BITS    (CW)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .op          (cell_op),
                .shift_up    (rle[gi]),
                .x           (sample_reg),
                .left_valid  (l_valid),
                .left_value  (l_value),
                .left_age    (l_age),
                .left_le     (l_le),
                .right_valid (r_valid),
                .right_value (r_value),
                .right_age   (r_age),
                .wrap_value  (c_value[0]),
                .wrap_age    (c_age[0]),
                .valid       (c_valid[gi]),
                .value       (c_value[gi]),
                .age         (c_age[gi]),
                .le          (c_le[gi])
            );
        end
    endgenerate

    // one-hot picks: expired entry, entry entering the k set, entry at the k boundary
    always_comb
    begin
        v_rem = '0;
        v_hi  = '0;
        v_km1 = '0;
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            v_rem = v_rem | (first[i]  ? c_value[i] : '0);
            v_hi  = v_hi  | (at_k[i]   ? c_value[i] : '0);
            v_km1 = v_km1 | (at_km1[i] ? c_value[i] : '0);
        end
    end

    assign any_flag = |flag;
    assign multi    = |(flag & below);
    assign r_in     = |(first & lt_kk);
    assign le_km1   = |(at_km1 & c_le);
    assign emit     = (fill_ext + KW'(1)) == wl_eff;

    always_comb
    begin
        state_next      = state_reg;
        window_len_next = window_len_reg;
        k_count_next    = k_count_reg;
        dirty_next      = dirty_reg;
        fill_next       = fill_reg;
        cnt_next        = cnt_reg;
        sum_next        = sum_reg;
        sample_next     = sample_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_sum_next    = out_sum_reg;

        if (cfg_we)
        begin
            priority if (cfg_index == CFG_WINDOW_LEN)
            begin
                window_len_next = cfg_data;
            end
            else if (cfg_index == CFG_K_COUNT)
            begin
                k_count_next = cfg_data;
                dirty_next   = 1'b1;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    sample_next = sample;
                    state_next  = ST_REMOVE;
                    if (dirty_reg)
                    begin
                        sum_next = '0;
                        cnt_next = '0;
                        if (fill_reg == '0)
                        begin
                            dirty_next = 1'b0;
                        end
                        else
                        begin
                            state_next = ST_SUMPASS;
                        end
                    end
                end
            end
            ST_SUMPASS:
            begin
                // head cell sweeps past the accumulator as the chain rotates
                if (KW'(cnt_reg) < kk)
                begin
                    sum_next = sum_reg + SUM_BITS'(c_value[0]);
                end
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == fill_reg - CW'(1))
                begin
                    dirty_next = 1'b0;
                    state_next = ST_REMOVE;
                end
            end
            ST_REMOVE:
            begin
                if (any_flag)
                begin
                    fill_next = fill_reg - CW'(1);
                    if (r_in)
                    begin
                        if (k_ext < fill_ext)
                        begin
                            sum_next = sum_reg - SUM_BITS'(v_rem) + SUM_BITS'(v_hi);
                        end
                        else
                        begin
                            sum_next = sum_reg - SUM_BITS'(v_rem);
                        end
                    end
                end
                if (!multi)
                begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                if (!stall)
                begin
                    fill_next = fill_reg + CW'(1);
                    if (k_ext != '0)
                    begin
                        if (k_ext > fill_ext)
                        begin
                            sum_next = sum_reg + SUM_BITS'(sample_reg);
                        end
                        else if (!le_km1)
                        begin
                            sum_next = sum_reg + SUM_BITS'(sample_reg) - SUM_BITS'(v_km1);
                        end
                    end
                    if (emit)
                    begin
                        out_valid_next = 1'b1;
                        out_sum_next   = sum_next;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            window_len_reg <= REG_BITS'(64);
            k_count_reg    <= REG_BITS'(1);
            dirty_reg      <= 1'b0;
            fill_reg       <= '0;
            sum_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            window_len_reg <= window_len_next;
            k_count_reg    <= k_count_next;
            dirty_reg      <= dirty_next;
            fill_reg       <= fill_next;
            sum_reg        <= sum_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg     <= cnt_next;
        sample_reg  <= sample_next;
        out_sum_reg <= out_sum_next;
    end

endmodule

`default_nettype wire
